/* rtl/dpcr_pkg.sv */
// ----------------------------------------------------------------------------
// dpcr_pkg
// Shared types, widths and helpers for the disc pair collision resolver.
// ----------------------------------------------------------------------------
package dpcr_pkg;

  localparam int unsigned FIELD_W   = 20;
  localparam int unsigned NUM_FIELD = 8;
  localparam int unsigned PAIR_W    = FIELD_W * NUM_FIELD;
  localparam int unsigned FLAG_W    = 2;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned REST_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 1'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd5120;
  localparam logic [REST_W-1:0]   REST_ONE   = 9'd256;

  // internal widths
  localparam int unsigned DIFF_W    = FIELD_W + 1;       // p1 - p2, v1 - v2
  localparam int unsigned PROD_W    = 2 * DIFF_W;        // one product of differences
  localparam int unsigned DSUM_W    = PROD_W + 1;        // dist2 and dot
  localparam int unsigned DIST_W    = RADIUS_W + 1;      // 2*radius and dist
  localparam int unsigned DIST2_W   = 2 * DIST_W;        // dist2 within contact
  localparam int unsigned SX_NUM_W  = DIST2_W + 1;
  localparam int unsigned SX_QUO_W  = DIST_W;
  localparam int unsigned VN_NUM_W  = 40;
  localparam int unsigned VN_QUO_W  = 23;
  localparam int unsigned SCALE_W   = REST_W + 1;        // 256 + e
  localparam int unsigned J_W       = 33;
  localparam int unsigned JD_W      = J_W + DIST_W;
  localparam int unsigned DV_SHIFT  = REST_W;            // divide by 512
  localparam int unsigned DV_NUM_W  = JD_W - DV_SHIFT;
  localparam int unsigned DV_QUO_W  = 24;
  localparam int unsigned SUM_W     = DV_QUO_W + 2;

  localparam int FIELD_MAX = 524287;
  localparam int FIELD_MIN = -524288;

  typedef logic signed [FIELD_W-1:0] field_t;

  // first field sits in the lowest bits
  typedef struct packed {
    field_t second_vel_y;
    field_t second_vel_x;
    field_t second_pos_y;
    field_t second_pos_x;
    field_t first_vel_y;
    field_t first_vel_x;
    field_t first_pos_y;
    field_t first_pos_x;
  } pair_t;

  function automatic field_t sat_field(input logic signed [SUM_W-1:0] v);
    field_t r;
    if (v > $signed(SUM_W'(FIELD_MAX))) begin
      r = field_t'(FIELD_MAX);
    end else if (v < $signed(SUM_W'(FIELD_MIN))) begin
      r = field_t'(FIELD_MIN);
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/dpcr_delay.sv */
// ----------------------------------------------------------------------------
// dpcr_delay
// Enabled delay line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module dpcr_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

/* rtl/dpcr_isqrt.sv */
// ----------------------------------------------------------------------------
// dpcr_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module dpcr_isqrt #(
  parameter int unsigned IN_W = 34
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int unsigned OUT_W = IN_W / 2;

  logic [IN_W-1:0] rem_q  [OUT_W];
  logic [IN_W-1:0] res_q  [OUT_W];
  logic [IN_W-1:0] rem_s  [OUT_W];
  logic [IN_W-1:0] res_s  [OUT_W];
  logic [IN_W-1:0] rem_d  [OUT_W];
  logic [IN_W-1:0] res_d  [OUT_W];
  logic [IN_W-1:0] bit_s  [OUT_W];
  logic [IN_W:0]   sum_s  [OUT_W];

  always_comb begin
    rem_s[0] = rad_i;
    res_s[0] = '0;
    for (int s = 1; s < OUT_W; s++) begin
      rem_s[s] = rem_q[s-1];
      res_s[s] = res_q[s-1];
    end
    for (int s = 0; s < OUT_W; s++) begin
      bit_s[s] = IN_W'(1) << (2 * (OUT_W - 1 - s));
      sum_s[s] = {1'b0, res_s[s]} + {1'b0, bit_s[s]};
      if ({1'b0, rem_s[s]} >= sum_s[s]) begin
        rem_d[s] = rem_s[s] - sum_s[s][IN_W-1:0];
        res_d[s] = (res_s[s] >> 1) + bit_s[s];
      end else begin
        rem_d[s] = rem_s[s];
        res_d[s] = res_s[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < OUT_W; s++) begin
        rem_q[s] <= rem_d[s];
        res_q[s] <= res_d[s];
      end
    end
  end

  assign root_o = res_q[OUT_W-1][OUT_W-1:0];

endmodule

/* rtl/dpcr_div.sv */
// ----------------------------------------------------------------------------
// dpcr_div
// Pipelined restoring divider, one quotient bit per stage, floor quotient.
// ----------------------------------------------------------------------------
module dpcr_div #(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned QUO_W = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned TRY_W = (DEN_W + QUO_W > NUM_W) ? DEN_W + QUO_W : NUM_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [NUM_W-1:0] rem_s [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];
  logic [QUO_W-1:0] quo_s [QUO_W];
  logic [NUM_W-1:0] rem_d [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];
  logic [TRY_W-1:0] try_s [QUO_W];

  always_comb begin
    rem_s[0] = num_i;
    den_s[0] = den_i;
    quo_s[0] = '0;
    for (int s = 1; s < QUO_W; s++) begin
      rem_s[s] = rem_q[s-1];
      den_s[s] = den_q[s-1];
      quo_s[s] = quo_q[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      // the trial is wide enough for the shifted divisor, so it never drops a set bit
      try_s[s] = TRY_W'(den_s[s]) << (QUO_W - 1 - s);
      quo_d[s] = quo_s[s];
      if (TRY_W'(rem_s[s]) >= try_s[s]) begin
        rem_d[s] = rem_s[s] - try_s[s][NUM_W-1:0];
        quo_d[s][QUO_W-1-s] = 1'b1;
      end else begin
        rem_d[s] = rem_s[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QUO_W; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_s[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

/* rtl/disc_pair_collision_resolve.sv */
// ----------------------------------------------------------------------------
// disc_pair_collision_resolve
// Contact resolution for two equal discs: separation push and impulse.
// ----------------------------------------------------------------------------
// One request carries the centre positions and velocities of two equal discs
// (signed Q11.8). When the centres are at most twice the radius apart and not
// coincident, both discs are pushed apart along the centre line until they
// touch; if they are also closing, an impulse of (1+restitution)/2 times the
// normal closing speed is applied with opposite signs. All results saturate
// to 20 bits. The block is a 72-stage pipeline and takes one request every
// clock: a 3-stage difference/square front end, a 17-stage square root for
// the centre distance, two more setup stages, a 23-stage divider for the
// normal speed (the push divider, 17 stages, runs beside it), three stages
// that form the impulse, and a 24-stage divider for the velocity change.
// Two output registers (output plus skid) let the pipe keep accepting
// while one result waits; with both full, s_axis_tready drops and every
// stage holds. Register writes are only valid while the block is idle.
// ----------------------------------------------------------------------------
module disc_pair_collision_resolve (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [dpcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dpcr_pkg::RADIUS_W-1:0]    cfg_data_i,
  // request side
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y,
  // second_pos_x, second_pos_y, second_vel_x, second_vel_y
  input  logic [dpcr_pkg::PAIR_W-1:0]      s_axis_tdata,
  // result side
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
  // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
  output logic [dpcr_pkg::PAIR_W-1:0]      m_axis_tdata,
  // in_contact, impulse_applied
  output logic [dpcr_pkg::FLAG_W-1:0]      m_axis_tuser
);

  import dpcr_pkg::*;

  localparam int unsigned SX_DEN_W = DIST_W + 1;
  localparam int unsigned PIPE_D   = 3 + DIST_W + 2 + VN_QUO_W + 3 + DV_QUO_W;

  // side data carried beside the square root
  typedef struct packed {
    pair_t                     pair;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DSUM_W-1:0]  dot;
    logic                      contact;
  } g3_t;

  // side data carried beside the normal speed divider
  typedef struct packed {
    pair_t             pair;
    logic              sdx;
    logic              sdy;
    logic [DIST_W-1:0] adx;
    logic [DIST_W-1:0] ady;
    logic              dneg;
    logic              contact;
    logic [DIST_W-1:0] cdist;
  } g22_t;

  // side data carried beside the velocity divider
  typedef struct packed {
    pair_t               pair;
    logic                sdx;
    logic                sdy;
    logic                dneg;
    logic                contact;
    logic [SX_QUO_W-1:0] sx;
    logic [SX_QUO_W-1:0] sy;
  } g48_t;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [RADIUS_W-1:0] radius_q;
  logic [REST_W-1:0]   rest_q;
  logic [DIST2_W-1:0]  tr2_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [DIST_W-1:0]   two_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rest_q   <= REST_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISC_RADIUS: radius_q <= cfg_data_i;
        CFG_RESTITUTION: rest_q   <= cfg_data_i[REST_W-1:0];
        default: ;
      endcase
    end
  end

  assign two_r = {radius_q, 1'b0};

  // derived constants follow the registers; they settle while the block idles
  always_ff @(posedge clk_i) begin
    tr2_q   <= DIST2_W'(two_r) * DIST2_W'(two_r);
    scale_q <= SCALE_W'(REST_ONE) + SCALE_W'((rest_q > REST_ONE) ? REST_ONE : rest_q);
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic              pipe_en;
  logic [PIPE_D-1:0] vld_q;
  logic              skid_v_q;

  assign pipe_en       = !skid_v_q;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_D-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // stages 1 to 3: differences, products, distance squared and dot product
  // --------------------------------------------------------------------------
  pair_t                    in_pair;
  pair_t                    s1_pair_q, s2_pair_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_rx_q, s1_ry_q;
  logic signed [DIFF_W-1:0] s2_dx_q, s2_dy_q;
  logic signed [PROD_W-1:0] s2_dxx_q, s2_dyy_q, s2_rdx_q, s2_rdy_q;
  logic [DSUM_W-1:0]        dist2_sum;
  logic signed [DSUM_W-1:0] dot_sum;
  g3_t                      s3_q;
  logic [DSUM_W-1:0]        s3_dist2_q;

  assign in_pair = pair_t'(s_axis_tdata);

  always_comb begin
    dist2_sum = DSUM_W'($unsigned(s2_dxx_q)) + DSUM_W'($unsigned(s2_dyy_q));
    dot_sum   = DSUM_W'(s2_rdx_q) + DSUM_W'(s2_rdy_q);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_pair_q <= in_pair;
      s1_dx_q   <= DIFF_W'(in_pair.first_pos_x) - DIFF_W'(in_pair.second_pos_x);
      s1_dy_q   <= DIFF_W'(in_pair.first_pos_y) - DIFF_W'(in_pair.second_pos_y);
      s1_rx_q   <= DIFF_W'(in_pair.first_vel_x) - DIFF_W'(in_pair.second_vel_x);
      s1_ry_q   <= DIFF_W'(in_pair.first_vel_y) - DIFF_W'(in_pair.second_vel_y);

      s2_pair_q <= s1_pair_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_dxx_q  <= s1_dx_q * s1_dx_q;
      s2_dyy_q  <= s1_dy_q * s1_dy_q;
      s2_rdx_q  <= s1_rx_q * s1_dx_q;
      s2_rdy_q  <= s1_ry_q * s1_dy_q;

      s3_q.pair    <= s2_pair_q;
      s3_q.dx      <= s2_dx_q;
      s3_q.dy      <= s2_dy_q;
      s3_q.dot     <= dot_sum;
      // coincident centres have no centre line: pass through
      s3_q.contact <= (dist2_sum != '0) && (dist2_sum <= DSUM_W'(tr2_q));
      s3_dist2_q   <= dist2_sum;
    end
  end

  // --------------------------------------------------------------------------
  // centre distance; only contact items need the root, so the low bits do
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] cdist;
  g3_t               g3_out;

  dpcr_isqrt #(
    .IN_W (DIST2_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .rad_i  (s3_dist2_q[DIST2_W-1:0]),
    .root_o (cdist)
  );

  dpcr_delay #(
    .WIDTH ($bits(g3_t)),
    .DEPTH (DIST_W)
  ) u_dly_g3 (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   (s3_q),
    .q_o   (g3_out)
  );

  // --------------------------------------------------------------------------
  // stages 21 and 22: push numerators and normal speed numerator
  // --------------------------------------------------------------------------
  logic [DIFF_W-1:0]   abs_dx, abs_dy;
  logic [DSUM_W-1:0]   abs_dot;
  logic [DIST_W-1:0]   gap;
  g22_t                s21_q, s22_q;
  logic [DIST2_W-1:0]  s21_prodx_q, s21_prody_q;
  logic [VN_NUM_W-1:0] s21_vnum_q, s22_vnum_q;
  logic [SX_NUM_W-1:0] s22_numx_q, s22_numy_q;

  always_comb begin
    abs_dx  = g3_out.dx[DIFF_W-1]  ? DIFF_W'(-g3_out.dx)  : DIFF_W'(g3_out.dx);
    abs_dy  = g3_out.dy[DIFF_W-1]  ? DIFF_W'(-g3_out.dy)  : DIFF_W'(g3_out.dy);
    abs_dot = g3_out.dot[DSUM_W-1] ? DSUM_W'(-g3_out.dot) : DSUM_W'(g3_out.dot);
    gap     = two_r - cdist;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s21_q.pair    <= g3_out.pair;
      s21_q.sdx     <= g3_out.dx[DIFF_W-1];
      s21_q.sdy     <= g3_out.dy[DIFF_W-1];
      s21_q.adx     <= abs_dx[DIST_W-1:0];
      s21_q.ady     <= abs_dy[DIST_W-1:0];
      s21_q.dneg    <= g3_out.dot[DSUM_W-1];
      s21_q.contact <= g3_out.contact;
      s21_q.cdist   <= cdist;
      s21_prodx_q   <= DIST2_W'(abs_dx[DIST_W-1:0]) * DIST2_W'(gap);
      s21_prody_q   <= DIST2_W'(abs_dy[DIST_W-1:0]) * DIST2_W'(gap);
      // round half away: add half the divisor to the magnitude
      s21_vnum_q    <= VN_NUM_W'(abs_dot[VN_NUM_W-1:0]) + VN_NUM_W'(cdist >> 1);

      s22_q      <= s21_q;
      s22_vnum_q <= s21_vnum_q;
      s22_numx_q <= SX_NUM_W'(s21_prodx_q) + SX_NUM_W'(s21_q.cdist);
      s22_numy_q <= SX_NUM_W'(s21_prody_q) + SX_NUM_W'(s21_q.cdist);
    end
  end

  // --------------------------------------------------------------------------
  // push and normal speed dividers
  // --------------------------------------------------------------------------
  logic [SX_DEN_W-1:0] den2;
  logic [SX_QUO_W-1:0] sx_quo, sy_quo, sx_al, sy_al;
  logic [VN_QUO_W-1:0] vn_quo;
  g22_t                g22_out;

  assign den2 = {s22_q.cdist, 1'b0};

  dpcr_div #(
    .NUM_W (SX_NUM_W),
    .DEN_W (SX_DEN_W),
    .QUO_W (SX_QUO_W)
  ) u_div_sx (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s22_numx_q),
    .den_i (den2),
    .quo_o (sx_quo)
  );

  dpcr_div #(
    .NUM_W (SX_NUM_W),
    .DEN_W (SX_DEN_W),
    .QUO_W (SX_QUO_W)
  ) u_div_sy (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s22_numy_q),
    .den_i (den2),
    .quo_o (sy_quo)
  );

  dpcr_div #(
    .NUM_W (VN_NUM_W),
    .DEN_W (DIST_W),
    .QUO_W (VN_QUO_W)
  ) u_div_vn (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s22_vnum_q),
    .den_i (s22_q.cdist),
    .quo_o (vn_quo)
  );

  // align the shorter push division with the normal speed
  dpcr_delay #(
    .WIDTH (2 * SX_QUO_W),
    .DEPTH (VN_QUO_W - SX_QUO_W)
  ) u_dly_sx (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   ({sx_quo, sy_quo}),
    .q_o   ({sx_al, sy_al})
  );

  dpcr_delay #(
    .WIDTH ($bits(g22_t)),
    .DEPTH (VN_QUO_W)
  ) u_dly_g22 (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   (s22_q),
    .q_o   (g22_out)
  );

  // --------------------------------------------------------------------------
  // stages 46 to 48: impulse and velocity change numerators
  // --------------------------------------------------------------------------
  g48_t                s46_q, s47_q, s48_q;
  logic [DIST_W-1:0]   s46_adx_q, s46_ady_q, s46_dist_q, s47_dist_q, s48_dist_q;
  logic [J_W-1:0]      s46_j_q;
  logic [JD_W-1:0]     s47_jx_q, s47_jy_q;
  logic [JD_W-1:0]     half_den, sumx, sumy;
  logic [DV_NUM_W-1:0] s48_ax_q, s48_ay_q;

  always_comb begin
    // half of 512*distance for rounding, then drop the power of two up front
    half_den = JD_W'(s47_dist_q) << (DV_SHIFT - 1);
    sumx     = s47_jx_q + half_den;
    sumy     = s47_jy_q + half_den;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s46_q.pair    <= g22_out.pair;
      s46_q.sdx     <= g22_out.sdx;
      s46_q.sdy     <= g22_out.sdy;
      s46_q.dneg    <= g22_out.dneg;
      s46_q.contact <= g22_out.contact;
      s46_q.sx      <= sx_al;
      s46_q.sy      <= sy_al;
      s46_adx_q     <= g22_out.adx;
      s46_ady_q     <= g22_out.ady;
      s46_dist_q    <= g22_out.cdist;
      s46_j_q       <= J_W'(scale_q) * J_W'(vn_quo);

      s47_q      <= s46_q;
      s47_dist_q <= s46_dist_q;
      s47_jx_q   <= JD_W'(s46_j_q) * JD_W'(s46_adx_q);
      s47_jy_q   <= JD_W'(s46_j_q) * JD_W'(s46_ady_q);

      s48_q      <= s47_q;
      s48_dist_q <= s47_dist_q;
      s48_ax_q   <= sumx[JD_W-1:DV_SHIFT];
      s48_ay_q   <= sumy[JD_W-1:DV_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // velocity change dividers
  // --------------------------------------------------------------------------
  logic [DV_QUO_W-1:0] dvx_quo, dvy_quo;
  g48_t                g48_out;

  dpcr_div #(
    .NUM_W (DV_NUM_W),
    .DEN_W (DIST_W),
    .QUO_W (DV_QUO_W)
  ) u_div_dvx (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s48_ax_q),
    .den_i (s48_dist_q),
    .quo_o (dvx_quo)
  );

  dpcr_div #(
    .NUM_W (DV_NUM_W),
    .DEN_W (DIST_W),
    .QUO_W (DV_QUO_W)
  ) u_div_dvy (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s48_ay_q),
    .den_i (s48_dist_q),
    .quo_o (dvy_quo)
  );

  dpcr_delay #(
    .WIDTH ($bits(g48_t)),
    .DEPTH (DV_QUO_W)
  ) u_dly_g48 (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   (s48_q),
    .q_o   (g48_out)
  );

  // --------------------------------------------------------------------------
  // final update and saturation
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sx_s, sy_s, dvx_s, dvy_s;
  logic                    imp;
  pair_t                   res_pair;
  logic [FLAG_W-1:0]       res_flag;

  always_comb begin
    imp   = g48_out.contact && g48_out.dneg;
    sx_s  = '0;
    sy_s  = '0;
    dvx_s = '0;
    dvy_s = '0;
    if (g48_out.contact) begin
      // push follows the sign of the centre line component
      sx_s = g48_out.sdx ? -SUM_W'(g48_out.sx) : SUM_W'(g48_out.sx);
      sy_s = g48_out.sdy ? -SUM_W'(g48_out.sy) : SUM_W'(g48_out.sy);
    end
    if (imp) begin
      dvx_s = g48_out.sdx ? -SUM_W'(dvx_quo) : SUM_W'(dvx_quo);
      dvy_s = g48_out.sdy ? -SUM_W'(dvy_quo) : SUM_W'(dvy_quo);
    end
    res_pair.first_pos_x  = sat_field(SUM_W'(g48_out.pair.first_pos_x) + sx_s);
    res_pair.first_pos_y  = sat_field(SUM_W'(g48_out.pair.first_pos_y) + sy_s);
    res_pair.first_vel_x  = sat_field(SUM_W'(g48_out.pair.first_vel_x) + dvx_s);
    res_pair.first_vel_y  = sat_field(SUM_W'(g48_out.pair.first_vel_y) + dvy_s);
    res_pair.second_pos_x = sat_field(SUM_W'(g48_out.pair.second_pos_x) - sx_s);
    res_pair.second_pos_y = sat_field(SUM_W'(g48_out.pair.second_pos_y) - sy_s);
    res_pair.second_vel_x = sat_field(SUM_W'(g48_out.pair.second_vel_x) - dvx_s);
    res_pair.second_vel_y = sat_field(SUM_W'(g48_out.pair.second_vel_y) - dvy_s);
    res_flag = {imp, g48_out.contact};
  end

  // --------------------------------------------------------------------------
  // output register plus skid register
  // --------------------------------------------------------------------------
  logic              out_v_q, push, pop;
  pair_t             out_pair_q, skid_pair_q;
  logic [FLAG_W-1:0] out_flag_q, skid_flag_q;

  assign push = pipe_en && vld_q[PIPE_D-1];
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      // drain the skid into the output once the held result goes
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_pair_q <= skid_pair_q;
        out_flag_q <= skid_flag_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_pair_q <= res_pair;
        skid_flag_q <= res_flag;
      end else begin
        out_pair_q <= res_pair;
        out_flag_q <= res_flag;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_pair_q;
  assign m_axis_tuser  = out_flag_q;

endmodule
